FILE: rtl/assert_macros.svh
// Assertion helpers used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define DPB_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");
`define DPB_ASSERT_NEXT(lbl, clk, rst, cond, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("assertion failed");
`else
`define DPB_ASSERT(lbl, clk, rst, prop)
`define DPB_ASSERT_NEXT(lbl, clk, rst, cond, prop)
`endif

`endif

FILE: rtl/dpb_pkg.sv
package dpb_pkg;

  localparam int MAX_COLS_DEF = 4096;
  localparam int MAX_ROWS_DEF = 4096;

  localparam int COL_W   = 12;
  localparam int ROW_W   = 12;
  localparam int DEPTH_W = 16;
  localparam int CLASS_W = 8;
  localparam int POS_W   = 32;

  localparam int FOCAL_W  = 19;
  localparam int CENTER_W = 20;
  localparam int SCALE_W  = 16;
  localparam int LIMIT_W  = 16;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;

  localparam logic [CFG_IDX_W-1:0] CFG_FOCAL_X     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FOCAL_Y     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DEPTH_SCALE = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_DEPTH_LIMIT = 3'd5;

  localparam logic [FOCAL_W-1:0]  FOCAL_X_RST     = 19'd157790;
  localparam logic [FOCAL_W-1:0]  FOCAL_Y_RST     = 19'd157887;
  localparam logic [CENTER_W-1:0] CENTER_X_RST    = 20'd81903;
  localparam logic [CENTER_W-1:0] CENTER_Y_RST    = 20'd62372;
  localparam logic [SCALE_W-1:0]  DEPTH_SCALE_RST = 16'd1000;
  localparam logic [LIMIT_W-1:0]  DEPTH_LIMIT_RST = 16'd30000;

  localparam logic [CLASS_W-1:0] SKY_CLASS = 8'd1;

  // offset magnitude, offset*depth, lateral divisor, lateral dividend
  localparam int OFS_W  = CENTER_W;
  localparam int PROD_W = OFS_W + DEPTH_W;
  localparam int LDEN_W = SCALE_W + FOCAL_W;
  localparam int LNUM_W = PROD_W + 16 + 1;
  localparam int ZNUM_W = DEPTH_W + 16 + 1;
  localparam int QUO_W  = POS_W;

  localparam logic [POS_W-1:0] POS_MAX = 32'h7FFF_FFFF;
  localparam logic [POS_W-1:0] POS_MIN = 32'h8000_0000;

endpackage

FILE: rtl/dpb_pix_if.sv
interface dpb_pix_if;
  logic                         valid;
  logic                         ready;
  logic [dpb_pkg::COL_W-1:0]    col;
  logic [dpb_pkg::ROW_W-1:0]    row;
  logic [dpb_pkg::DEPTH_W-1:0]  depth;
  logic                         selected;
  logic [dpb_pkg::CLASS_W-1:0]  seg_class;

  modport source (output valid, col, row, depth, selected, seg_class, input ready);
  modport sink (input valid, col, row, depth, selected, seg_class, output ready);
endinterface

FILE: rtl/dpb_pt_if.sv
interface dpb_pt_if;
  logic                       valid;
  logic                       ready;
  logic [dpb_pkg::POS_W-1:0]  pos_x;
  logic [dpb_pkg::POS_W-1:0]  pos_y;
  logic [dpb_pkg::POS_W-1:0]  pos_z;

  modport source (output valid, pos_x, pos_y, pos_z, input ready);
  modport sink (input valid, pos_x, pos_y, pos_z, output ready);
endinterface

FILE: rtl/dpb_div.sv
// Pipelined restoring divider, one quotient bit per stage.
// Stages advance only on en. ovf set when the quotient needs more than QW bits.
module dpb_div #(
  parameter int NW = 53,
  parameter int DW = 35,
  parameter int QW = 32
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [QW-1:0] quo,
  output logic          ovf
);

  localparam int HW = NW - QW;

  logic [HW-1:0] hi;
  logic [DW-1:0] rem  [QW+1];
  logic [QW-1:0] lo   [QW+1];
  logic [QW-1:0] q    [QW+1];
  logic          ov   [QW+1];

  assign hi = num[NW-1:QW];

  always_ff @(posedge clk) begin
    if (en) begin
      ov[0]  <= ({{DW{1'b0}}, hi} >= {{HW{1'b0}}, den});
      rem[0] <= DW'(hi);
      lo[0]  <= num[QW-1:0];
      q[0]   <= '0;
    end
  end

  for (genvar k = 1; k <= QW; k++) begin : g_stage
    logic [DW:0] t;
    logic        ge;
    assign t  = {rem[k-1], lo[k-1][QW-1]};
    assign ge = (t >= {1'b0, den});
    always_ff @(posedge clk) begin
      if (en) begin
        rem[k] <= ge ? DW'(t - {1'b0, den}) : DW'(t);
        lo[k]  <= {lo[k-1][QW-2:0], 1'b0};
        q[k]   <= {q[k-1][QW-2:0], ge};
        ov[k]  <= ov[k-1];
      end
    end
  end

  assign quo = q[QW];
  assign ovf = ov[QW];

endmodule

FILE: rtl/depth_pixel_backprojection_unit.sv
// Channel  Dir  Beat
// in_pix   in   col, row, depth, selected, seg_class
// out_pt   out  pos_x, pos_y, pos_z (one per kept pixel)
// cfg_*    in   cfg_index, cfg_data (one register per write)
//
// One pixel per cycle while out_pt does not stall; the path to out_pt has 3 front stages,
// 33 divider stages from the bit-per-stage dividers, and an output register.
// Rejected pixels flow through as empty slots and produce no beat.
// rst is synchronous; configuration returns to its preset values.
// A stall on out_pt freezes the whole pipe; in_pix.ready drops with it.
`include "assert_macros.svh"

module depth_pixel_backprojection_unit #(
  parameter int MAX_COLS = dpb_pkg::MAX_COLS_DEF,
  parameter int MAX_ROWS = dpb_pkg::MAX_ROWS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [dpb_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [dpb_pkg::CFG_DATA_W-1:0]    cfg_data,
  dpb_pix_if.sink                           in_pix,
  dpb_pt_if.source                          out_pt
);

  localparam int QW = dpb_pkg::QUO_W;

  logic [dpb_pkg::FOCAL_W-1:0]  focal_x, focal_y;
  logic [dpb_pkg::CENTER_W-1:0] center_x, center_y;
  logic [dpb_pkg::SCALE_W-1:0]  depth_scale;
  logic [dpb_pkg::LIMIT_W-1:0]  depth_limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      focal_x     <= dpb_pkg::FOCAL_X_RST;
      focal_y     <= dpb_pkg::FOCAL_Y_RST;
      center_x    <= dpb_pkg::CENTER_X_RST;
      center_y    <= dpb_pkg::CENTER_Y_RST;
      depth_scale <= dpb_pkg::DEPTH_SCALE_RST;
      depth_limit <= dpb_pkg::DEPTH_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        dpb_pkg::CFG_FOCAL_X:     focal_x     <= cfg_data[dpb_pkg::FOCAL_W-1:0];
        dpb_pkg::CFG_FOCAL_Y:     focal_y     <= cfg_data[dpb_pkg::FOCAL_W-1:0];
        dpb_pkg::CFG_CENTER_X:    center_x    <= cfg_data[dpb_pkg::CENTER_W-1:0];
        dpb_pkg::CFG_CENTER_Y:    center_y    <= cfg_data[dpb_pkg::CENTER_W-1:0];
        dpb_pkg::CFG_DEPTH_SCALE: depth_scale <= cfg_data[dpb_pkg::SCALE_W-1:0];
        dpb_pkg::CFG_DEPTH_LIMIT: depth_limit <= cfg_data[dpb_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // derived divisors, zero treated as one
  logic [dpb_pkg::SCALE_W-1:0] scale_eff;
  logic [dpb_pkg::FOCAL_W-1:0] fx_eff, fy_eff;
  logic [dpb_pkg::LDEN_W-1:0]  den_x, den_y;

  assign scale_eff = (depth_scale == '0) ? dpb_pkg::SCALE_W'(1) : depth_scale;
  assign fx_eff    = (focal_x == '0) ? dpb_pkg::FOCAL_W'(1) : focal_x;
  assign fy_eff    = (focal_y == '0) ? dpb_pkg::FOCAL_W'(1) : focal_y;

  always_ff @(posedge clk) begin
    den_x <= dpb_pkg::LDEN_W'(scale_eff) * dpb_pkg::LDEN_W'(fx_eff);
    den_y <= dpb_pkg::LDEN_W'(scale_eff) * dpb_pkg::LDEN_W'(fy_eff);
  end

  logic en;
  assign en = !out_pt.valid || out_pt.ready;
  assign in_pix.ready = en;

  // stage 1: filter and center offsets
  logic keep;
  assign keep = in_pix.valid && in_pix.selected && (in_pix.depth != '0)
             && (in_pix.depth < depth_limit) && (in_pix.seg_class != dpb_pkg::SKY_CLASS)
             && (int'(in_pix.col) < MAX_COLS) && (int'(in_pix.row) < MAX_ROWS);

  logic [dpb_pkg::CENTER_W-1:0] px, py;
  assign px = {in_pix.col, 8'd0};
  assign py = {in_pix.row, 8'd0};

  logic                          v1, nx1, ny1;
  logic [dpb_pkg::OFS_W-1:0]     mx1, my1;
  logic [dpb_pkg::DEPTH_W-1:0]   d1;

  // stage 2: products and depth dividend
  logic                          v2, nx2, ny2;
  logic [dpb_pkg::PROD_W-1:0]    prx2, pry2;
  logic [dpb_pkg::ZNUM_W-1:0]    nz2;

  // stage 3: dividends
  logic                          v3, nx3, ny3;
  logic [dpb_pkg::LNUM_W-1:0]    nmx3, nmy3;
  logic [dpb_pkg::ZNUM_W-1:0]    nz3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (en) begin
      v1 <= keep;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nx1  <= px < center_x;
      ny1  <= py < center_y;
      mx1  <= (px < center_x) ? center_x - px : px - center_x;
      my1  <= (py < center_y) ? center_y - py : py - center_y;
      d1   <= in_pix.depth;

      nx2  <= nx1;
      ny2  <= ny1;
      prx2 <= dpb_pkg::PROD_W'(mx1) * dpb_pkg::PROD_W'(d1);
      pry2 <= dpb_pkg::PROD_W'(my1) * dpb_pkg::PROD_W'(d1);
      nz2  <= dpb_pkg::ZNUM_W'({d1, 16'd0}) + dpb_pkg::ZNUM_W'(scale_eff >> 1);

      nx3  <= nx2;
      ny3  <= ny2;
      nmx3 <= dpb_pkg::LNUM_W'({prx2, 16'd0}) + dpb_pkg::LNUM_W'(den_x >> 1);
      nmy3 <= dpb_pkg::LNUM_W'({pry2, 16'd0}) + dpb_pkg::LNUM_W'(den_y >> 1);
      nz3  <= nz2;
    end
  end

  logic vd [QW+1];
  logic ndx [QW+1];
  logic ndy [QW+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= QW; k++) vd[k] <= 1'b0;
    end else if (en) begin
      vd[0] <= v3;
      for (int k = 1; k <= QW; k++) vd[k] <= vd[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ndx[0] <= nx3;
      ndy[0] <= ny3;
      for (int k = 1; k <= QW; k++) begin
        ndx[k] <= ndx[k-1];
        ndy[k] <= ndy[k-1];
      end
    end
  end

  logic [QW-1:0] qx, qy, qz;
  logic          ox, oy, oz;

  dpb_div #(.NW(dpb_pkg::LNUM_W), .DW(dpb_pkg::LDEN_W), .QW(QW)) u_div_x (
    .clk(clk), .en(en), .num(nmx3), .den(den_x), .quo(qx), .ovf(ox)
  );
  dpb_div #(.NW(dpb_pkg::LNUM_W), .DW(dpb_pkg::LDEN_W), .QW(QW)) u_div_y (
    .clk(clk), .en(en), .num(nmy3), .den(den_y), .quo(qy), .ovf(oy)
  );
  dpb_div #(.NW(dpb_pkg::ZNUM_W), .DW(dpb_pkg::SCALE_W), .QW(QW)) u_div_z (
    .clk(clk), .en(en), .num(nz3), .den(scale_eff), .quo(qz), .ovf(oz)
  );

  function automatic logic [dpb_pkg::POS_W-1:0] sat(
    input logic neg, input logic ovf, input logic [dpb_pkg::POS_W-1:0] mag
  );
    logic big;
    big = ovf || mag[dpb_pkg::POS_W-1];
    if (neg) begin
      sat = (big && (mag != dpb_pkg::POS_MIN || ovf)) ? dpb_pkg::POS_MIN : (~mag + 1'b1);
    end else begin
      sat = big ? dpb_pkg::POS_MAX : mag;
    end
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      out_pt.valid <= 1'b0;
    end else if (en) begin
      out_pt.valid <= vd[QW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_pt.pos_x <= sat(ndx[QW], ox, qx);
      out_pt.pos_y <= sat(ndy[QW], oy, qy);
      out_pt.pos_z <= oz ? '1 : qz;
    end
  end

  `DPB_ASSERT_NEXT(a_zero_depth_dropped, clk, rst, in_pix.ready && in_pix.depth == '0, !v1)
  `DPB_ASSERT(a_z_nonzero, clk, rst, out_pt.valid |-> out_pt.pos_z != '0)
  `DPB_ASSERT_NEXT(a_stall_freezes, clk, rst, !in_pix.ready, $stable(out_pt.pos_x))

endmodule
